### rtl/core/hmtv_pkg.sv
// Package for the heightmap terrain vertex generator: widths, codes, shared types.
// No dependencies; every other file of the block uses it.
`default_nettype none

package hmtv_pkg;

  localparam int MAX_SIDE   = 256;
  localparam int SIDE_W     = 9;
  localparam int COORD_W    = 8;
  localparam int ADDR_W     = 16;
  localparam int HGT_W      = 8;
  localparam int CNT_W      = 17;
  localparam int IDX_W      = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SPACING_W  = 16;
  localparam int POS_W      = 24;
  localparam int TEX_W      = 17;
  localparam int NRM_W      = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;

  localparam int DIV_NUM_W  = 25;
  localparam int DIV_DEN_W  = 10;
  localparam int DIV_CNT_W  = 5;

  localparam int NXZ_W      = 13;
  localparam int NY_W       = 23;
  localparam int S10_W      = 20;
  localparam int Q_W        = 46;
  localparam int P_W        = 82;
  localparam int STEP_W     = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_WIDTH = 2'd0,
    REG_GRID_DEPTH = 2'd1,
    REG_SPACING    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [SIDE_W-1:0]    w;
    logic [SIDE_W-1:0]    d;
    logic [SPACING_W-1:0] spacing;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [HGT_W-1:0]  data;
  } wr_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    logic               last;
  } job_t;

endpackage

`default_nettype wire

### rtl/core/hmtv_if.sv
// Channel interfaces: input items, vertex results and configuration writes.
// Depends on hmtv_pkg.
`default_nettype none

interface hmtv_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [hmtv_pkg::HGT_W-1:0] height_sample;
  modport source (output valid, op, height_sample, input ready);
  modport sink (input valid, op, height_sample, output ready);
endinterface

interface hmtv_out_if;
  logic                              valid;
  logic                              ready;
  logic [hmtv_pkg::POS_W-1:0]        pos_x;
  logic [hmtv_pkg::HGT_W-1:0]        height_raw;
  logic [hmtv_pkg::POS_W-1:0]        pos_z;
  logic [hmtv_pkg::TEX_W-1:0]        tex_u;
  logic [hmtv_pkg::TEX_W-1:0]        tex_v;
  logic signed [hmtv_pkg::NRM_W-1:0] normal_x;
  logic [hmtv_pkg::NRM_W-2:0]        normal_y;
  logic signed [hmtv_pkg::NRM_W-1:0] normal_z;
  logic                              last_vertex;
  modport source (output valid, pos_x, height_raw, pos_z, tex_u, tex_v, normal_x, normal_y,
                  normal_z, last_vertex, input ready);
  modport sink (input valid, pos_x, height_raw, pos_z, tex_u, tex_v, normal_x, normal_y,
                normal_z, last_vertex, output ready);
endinterface

interface hmtv_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hmtv_pkg::IDX_W-1:0]      index;
  logic [hmtv_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/hmtv_fifo.sv
// Four-entry job queue between the front and the back of the vertex generator.
// Depends on hmtv_pkg.
`default_nettype none

module hmtv_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hmtv_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output hmtv_pkg::job_t head
);
  import hmtv_pkg::*;

  job_t                  slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign head    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (FIFO_PTR_W+1)'(do_push) - (FIFO_PTR_W+1)'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_PTR_W+1)'(FIFO_DEPTH)) else $error("queue count over depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1) else $error("queue count slip");
`endif

endmodule

`default_nettype wire

### rtl/core/hmtv_div.sv
// Restoring divider, one quotient bit per cycle, for the texture coordinates.
// Depends on hmtv_pkg.
`default_nettype none

module hmtv_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [hmtv_pkg::DIV_NUM_W-1:0] num,
  input  logic [hmtv_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [hmtv_pkg::TEX_W-1:0]     quo
);
  import hmtv_pkg::*;

  logic [DIV_NUM_W-1:0] shreg;
  logic [DIV_DEN_W-1:0] dreg;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W:0]   trial;
  logic                 ge;
  logic [DIV_DEN_W-1:0] rem_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;

  assign trial    = {rem, shreg[DIV_NUM_W-1]};
  assign ge       = (trial >= {1'b0, dreg});
  assign rem_next = ge ? DIV_DEN_W'(trial - {1'b0, dreg}) : trial[DIV_DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= num;
      dreg  <= den;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[DIV_NUM_W-2:0], 1'b0};
      rem   <= rem_next;
      quo   <= {quo[TEX_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(DIV_NUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/hmtv_front.sv
// Front end: takes input items, stores height samples, queues vertex jobs.
// Depends on hmtv_pkg and hmtv_if.
`default_nettype none

module hmtv_front (
  input  logic           clk,
  input  logic           rst,
  hmtv_in_if.sink        item,
  input  hmtv_pkg::cfg_t cfg,
  input  logic           clr,
  output hmtv_pkg::wr_t  wr,
  output logic           push,
  output hmtv_pkg::job_t push_data,
  input  logic           full
);
  import hmtv_pkg::*;

  logic [2*SIDE_W-1:0]  total_p;
  logic [CNT_W-1:0]     total;
  logic [CNT_W-1:0]     load_count;
  logic [COORD_W-1:0]   x;
  logic [COORD_W-1:0]   z;
  logic                 done;
  logic                 acc;
  logic                 x_end;
  logic                 z_end;

  assign total_p = cfg.w * cfg.d;
  assign total   = total_p[CNT_W-1:0];
  assign item.ready = !full;
  assign acc   = item.valid && item.ready;
  assign x_end = ({1'b0, x} == cfg.w - 1'b1);
  assign z_end = ({1'b0, z} == cfg.d - 1'b1);

  assign wr.we   = acc && (item.op == OP_LOAD) && (load_count < total);
  assign wr.addr = load_count[ADDR_W-1:0];
  assign wr.data = item.height_sample;

  assign push           = acc && (item.op == OP_EMIT) && !done;
  assign push_data.x    = x;
  assign push_data.z    = z;
  assign push_data.last = x_end && z_end;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      load_count <= '0;
      x          <= '0;
      z          <= '0;
      done       <= 1'b0;
    end else begin
      if (wr.we) begin
        load_count <= load_count + 1'b1;
      end
      if (push) begin
        if (x_end && z_end) begin
          done <= 1'b1;
        end else if (x_end) begin
          x <= '0;
          z <= z + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/hmtv_back.sv
// Back end: height memory, neighbor reads, normal accumulation and normalization,
// texture dividers and the vertex output register. Depends on hmtv_pkg, hmtv_if, hmtv_div.
`default_nettype none

module hmtv_back (
  input  logic           clk,
  input  logic           rst,
  input  hmtv_pkg::cfg_t cfg,
  input  hmtv_pkg::wr_t  wr,
  input  logic           empty,
  input  hmtv_pkg::job_t head,
  output logic           pop,
  hmtv_out_if.source     vertex
);
  import hmtv_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_RD   = 9'b000000010,
    ST_NY   = 9'b000000100,
    ST_SQ   = 9'b000001000,
    ST_QS   = 9'b000010000,
    ST_MSQ  = 9'b000100000,
    ST_ITER = 9'b001000000,
    ST_FIN  = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t state;

  logic [HGT_W-1:0] mem [MAX_SIDE*MAX_SIDE];
  logic [HGT_W-1:0] rdata;
  logic [ADDR_W-1:0] raddr;

  job_t              job;
  logic [STEP_W-1:0] s;
  logic [STEP_W-1:0] dstep;
  logic              dvld;
  logic [HGT_W-1:0]  ha, hb, hc, hraw;
  logic signed [NXZ_W-1:0] nx, nz, nx_next, nz_next;
  logic [2:0]        k, k_next;
  logic [NY_W-1:0]   ny;
  logic [2*NXZ_W-1:0] sqx, sqz;
  logic [Q_W-1:0]    sqy;
  logic [Q_W-1:0]    q;
  logic [POS_W-1:0]  posx, posz;
  logic [1:0]        ci;
  logic              neg;
  logic signed [P_W-1:0] rr, pp, tt, pc, q_ext;
  logic [NRM_W-1:0]  r;
  logic [3:0]        b;
  logic [NRM_W-1:0]  nrm_x, nrm_y, nrm_z, nrm_val;
  logic              ovld;
  logic              out_free;

  // read address of the current step: four cells of four corners, then the vertex
  logic [1:0]         cj, ck;
  logic [SIDE_W-1:0]  col_p1, row_p1;
  logic [ADDR_W-1:0]  col16, row16;
  logic [2*ADDR_W-1:0] prod;

  assign cj = s[3:2];
  assign ck = s[1:0];
  always_comb begin
    if (s[STEP_W-1]) begin
      col_p1 = {1'b0, job.x} + 1'b1;
      row_p1 = {1'b0, job.z} + 1'b1;
    end else begin
      col_p1 = {1'b0, job.x} + SIDE_W'(cj[0]) + SIDE_W'(ck == 2'd1 || ck == 2'd2);
      row_p1 = {1'b0, job.z} + SIDE_W'(cj[1]) + SIDE_W'(ck == 2'd0 || ck == 2'd1);
    end
  end
  assign col16 = ADDR_W'(col_p1) - 1'b1;
  assign row16 = ADDR_W'(row_p1) - 1'b1;
  assign prod  = row16 * ADDR_W'(cfg.w);
  assign raddr = prod[ADDR_W-1:0] + col16;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

  // cell validity and triangle membership for the arriving corner
  logic       vx0, vx1, vz0, vz1, cell_ok, t1, t2;
  logic [1:0] dj;
  logic signed [NXZ_W-1:0] sa, sb, sc, sd;

  assign vx0 = (job.x != '0);
  assign vx1 = ({1'b0, job.x} != cfg.w - 1'b1);
  assign vz0 = (job.z != '0);
  assign vz1 = ({1'b0, job.z} != cfg.d - 1'b1);
  assign dj  = dstep[3:2];
  assign cell_ok = (dj[0] ? vx1 : vx0) && (dj[1] ? vz1 : vz0);
  assign t1 = cell_ok && (dj != 2'd3);
  assign t2 = cell_ok && (dj != 2'd0);
  assign sa = signed'(NXZ_W'(ha));
  assign sb = signed'(NXZ_W'(hb));
  assign sc = signed'(NXZ_W'(hc));
  assign sd = signed'(NXZ_W'(rdata));

  always_comb begin
    nx_next = nx;
    nz_next = nz;
    k_next  = k;
    if (t1) begin
      nx_next = nx_next + (sa - sb);
      nz_next = nz_next + (sc - sb);
    end
    if (t2) begin
      nx_next = nx_next + (sd - sc);
      nz_next = nz_next + (sd - sa);
    end
    k_next = k + 3'(t1) + 3'(t2);
  end

  // normal arithmetic
  logic [S10_W-1:0]  s10;
  logic signed [NY_W:0] comp;
  logic [NY_W:0]     mabs;
  logic [Q_W-1:0]    msq;
  logic [5:0]        sh_t, sh_q;

  assign s10 = (S10_W'(cfg.spacing) << 3) + (S10_W'(cfg.spacing) << 1);
  always_comb begin
    unique case (ci)
      2'd0:    comp = (NY_W+1)'(nx);
      2'd1:    comp = signed'({1'b0, ny});
      default: comp = (NY_W+1)'(nz);
    endcase
  end
  assign mabs  = comp[NY_W] ? unsigned'(-comp) : unsigned'(comp);
  assign msq   = Q_W'(mabs[NY_W-1:0]) * Q_W'(mabs[NY_W-1:0]);
  assign q_ext = signed'(P_W'(q));
  assign sh_t  = 6'(b) + 6'd2;
  assign sh_q  = 6'({b, 1'b0}) + 6'd2;
  assign pc    = pp + (tt <<< sh_t) + (q_ext <<< sh_q);

  always_comb begin
    if (q == '0) begin
      nrm_val = '0;
    end else if (neg) begin
      nrm_val = NRM_W'(-r);
    end else if (r[NRM_W-1]) begin
      nrm_val = {1'b0, {(NRM_W-1){1'b1}}};
    end else begin
      nrm_val = r;
    end
  end

  // texture dividers
  logic                 udone, vdone;
  logic [TEX_W-1:0]     uq, vq;
  logic [SIDE_W-1:0]    wm1, dm1;
  logic [DIV_NUM_W-1:0] unum, vnum;

  assign wm1  = cfg.w - 1'b1;
  assign dm1  = cfg.d - 1'b1;
  assign unum = {head.x, {TEX_W{1'b0}}} + DIV_NUM_W'(wm1);
  assign vnum = {head.z, {TEX_W{1'b0}}} + DIV_NUM_W'(dm1);
  assign pop  = (state == ST_IDLE) && !empty;

  hmtv_div u_udiv (
    .clk(clk), .rst(rst), .start(pop), .num(unum), .den({wm1, 1'b0}),
    .done(udone), .quo(uq)
  );
  hmtv_div u_vdiv (
    .clk(clk), .rst(rst), .start(pop), .num(vnum), .den({dm1, 1'b0}),
    .done(vdone), .quo(vq)
  );

  assign out_free = !ovld || vertex.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      dvld  <= 1'b0;
      ovld  <= 1'b0;
    end else begin
      dvld <= (state == ST_RD) && (s <= STEP_W'(16));
      if (ovld && vertex.ready) begin
        ovld <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          if (dvld && dstep[STEP_W-1]) begin
            state <= ST_NY;
          end
        end
        ST_NY:   state <= ST_SQ;
        ST_SQ:   state <= ST_QS;
        ST_QS:   state <= ST_MSQ;
        ST_MSQ:  state <= ST_ITER;
        ST_ITER: begin
          if (b == '0) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= (ci == 2'd2) ? ST_OUT : ST_MSQ;
        end
        ST_OUT: begin
          if (udone && vdone && out_free) begin
            ovld  <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dstep <= s;
    unique case (state)
      ST_IDLE: begin
        job <= head;
        s   <= '0;
        nx  <= '0;
        nz  <= '0;
        k   <= '0;
      end
      ST_RD: begin
        if (s <= STEP_W'(16)) begin
          s <= s + 1'b1;
        end
        if (dvld) begin
          if (dstep[STEP_W-1]) begin
            hraw <= rdata;
          end else begin
            unique case (dstep[1:0])
              2'd0: ha <= rdata;
              2'd1: hb <= rdata;
              2'd2: hc <= rdata;
              default: begin
                nx <= nx_next;
                nz <= nz_next;
                k  <= k_next;
              end
            endcase
          end
        end
      end
      ST_NY: begin
        ny   <= NY_W'(k) * NY_W'(s10);
        posx <= POS_W'(job.x) * POS_W'(cfg.spacing);
        posz <= POS_W'(job.z) * POS_W'(cfg.spacing);
      end
      ST_SQ: begin
        sqx <= unsigned'((2*NXZ_W)'(nx) * (2*NXZ_W)'(nx));
        sqy <= Q_W'(ny) * Q_W'(ny);
        sqz <= unsigned'((2*NXZ_W)'(nz) * (2*NXZ_W)'(nz));
      end
      ST_QS: begin
        q  <= Q_W'(sqx) + sqy + Q_W'(sqz);
        ci <= 2'd0;
      end
      ST_MSQ: begin
        neg <= comp[NY_W];
        rr  <= signed'(P_W'({msq, 32'b0}));
        pp  <= q_ext;
        tt  <= -q_ext;
        r   <= '0;
        b   <= 4'd15;
      end
      ST_ITER: begin
        if (pc <= rr) begin
          pp   <= pc;
          tt   <= tt + (q_ext <<< (6'(b) + 6'd1));
          r[b] <= 1'b1;
        end
        b <= b - 1'b1;
      end
      ST_FIN: begin
        unique case (ci)
          2'd0:    nrm_x <= nrm_val;
          2'd1:    nrm_y <= nrm_val;
          default: nrm_z <= nrm_val;
        endcase
        ci <= ci + 1'b1;
      end
      ST_OUT: begin
        if (udone && vdone && out_free) begin
          vertex.pos_x       <= posx;
          vertex.height_raw  <= hraw;
          vertex.pos_z       <= posz;
          vertex.tex_u       <= uq;
          vertex.tex_v       <= vq;
          vertex.normal_x    <= signed'(nrm_x);
          vertex.normal_y    <= nrm_y[NRM_W-2:0];
          vertex.normal_z    <= signed'(nrm_z);
          vertex.last_vertex <= job.last;
        end
      end
      default: ;
    endcase
  end

  assign vertex.valid = ovld;

`ifndef ASSERT_OFF
  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == ST_RD) else $error("job popped without read phase");
  a_iter_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ITER && b == '0) |=> state == ST_FIN) else $error("normalize loop overrun");
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(ovld) |-> $past(state == ST_OUT && udone && vdone))
    else $error("vertex shown before its work finished");
`endif

endmodule

`default_nettype wire

### rtl/core/heightmap_terrain_vertex_gen_top.sv
// Top level of the heightmap terrain vertex generator: configuration registers,
// front end, job queue and back end. Depends on hmtv_pkg, hmtv_if and all hmtv_* modules.
`default_nettype none

// A height sample (op 0) is stored as it is accepted, so a grid loads at one byte
// per clock while the job queue has room. A vertex (op 1) is queued as it is accepted;
// the back end then makes seventeen reads through the single read port of the height
// memory, forms the squared length in ST_NY, ST_SQ and ST_QS, and works out each of
// the three normal components with a 16-step normalize loop; it takes a new job only
// from idle. Texture dividers run alongside. Up to four vertex jobs wait in a queue, and
// a finished vertex sits in an output register. The height memory needs no clearing
// after reset; a write to any defined register restarts loading and emitting.

module heightmap_terrain_vertex_gen_top (
  input  logic       clk,
  input  logic       rst,
  hmtv_in_if.sink    item,
  hmtv_cfg_if.sink   cfg,
  hmtv_out_if.source vertex
);
  import hmtv_pkg::*;

  logic [SIDE_W-1:0]    grid_width;
  logic [SIDE_W-1:0]    grid_depth;
  logic [SPACING_W-1:0] spacing;
  cfg_t                 eff;
  logic                 clr;
  wr_t                  wr;
  logic                 push;
  job_t                 push_data;
  logic                 full;
  logic                 empty;
  logic                 pop;
  job_t                 head;

  assign cfg.ready = 1'b1;

  // counters restart at the same edge as the register transfer
  assign clr = cfg.valid && cfg.ready &&
               (cfg.index == REG_GRID_WIDTH || cfg.index == REG_GRID_DEPTH ||
                cfg.index == REG_SPACING);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= SIDE_W'(129);
      grid_depth <= SIDE_W'(129);
      spacing    <= SPACING_W'(1);
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          REG_GRID_WIDTH: begin
            grid_width <= cfg.data[SIDE_W-1:0];
          end
          REG_GRID_DEPTH: begin
            grid_depth <= cfg.data[SIDE_W-1:0];
          end
          REG_SPACING: begin
            spacing <= cfg.data;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (grid_width < SIDE_W'(2)) begin
      eff.w = SIDE_W'(2);
    end else if (grid_width > SIDE_W'(MAX_SIDE)) begin
      eff.w = SIDE_W'(MAX_SIDE);
    end else begin
      eff.w = grid_width;
    end
    if (grid_depth < SIDE_W'(2)) begin
      eff.d = SIDE_W'(2);
    end else if (grid_depth > SIDE_W'(MAX_SIDE)) begin
      eff.d = SIDE_W'(MAX_SIDE);
    end else begin
      eff.d = grid_depth;
    end
    eff.spacing = spacing;
  end

  hmtv_front u_front (
    .clk(clk), .rst(rst), .item(item), .cfg(eff), .clr(clr), .wr(wr),
    .push(push), .push_data(push_data), .full(full)
  );

  hmtv_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .full(full),
    .pop(pop), .empty(empty), .head(head)
  );

  hmtv_back u_back (
    .clk(clk), .rst(rst), .cfg(eff), .wr(wr), .empty(empty), .head(head),
    .pop(pop), .vertex(vertex)
  );

endmodule

`default_nettype wire
